### hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// shared constants, types and helpers of the masked byte pattern search
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = IDX_W + 1;
  localparam int ADDR_W      = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS   = 3'd0,
    CFG_PATTERN_LOW    = 3'd1,
    CFG_PATTERN_HIGH   = 3'd2,
    CFG_CARE_MASK      = 3'd3,
    CFG_PATTERN_LENGTH = 3'd4
  } cfg_reg_t;

  // shift control shared by every cell of the window
  typedef struct packed {
    logic shift_en;
    logic clear;
  } cell_ctl_t;

  // per-cell compare setup
  typedef struct packed {
    logic       care_en;
    logic [7:0] pat_byte;
  } cell_cmp_t;

  // clamp the programmed length to 1..MAX_PATTERN
  function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] n;
    n = len;
    if (n == '0) begin
      n = LEN_W'(1);
    end else if (n > LEN_W'(MAX_PATTERN)) begin
      n = LEN_W'(MAX_PATTERN);
    end
    return n;
  endfunction

endpackage

### hdl/masked_byte_pattern_search.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search
// a result shows on out_valid in the cycle after the byte that causes it
// throughput: one byte per cycle while in_stall is low, set by the compare across the cell chain
// the output register lets the next byte in while a result is being taken
// reset (synchronous, rst_n low): registers to defaults, window and count
// cleared, no result pending; no clearing pass needed
// ----------------------------------------------------------------------------
module masked_byte_pattern_search
  import mbps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // byte stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  // result
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_found,
  output logic [ADDR_W-1:0]     out_match_address,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [ADDR_W-1:0]      base_r;
  logic [63:0]            pat_low_r;
  logic [63:0]            pat_high_r;
  logic [MAX_PATTERN-1:0] care_r;
  logic [LEN_W-1:0]       len_r;

  // region state
  logic [ADDR_W-1:0] count_r, count_nxt, count_inc;
  logic              done_r, done_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;

  logic                   in_accept;
  logic [LEN_W-1:0]       n_used;
  logic [8*MAX_PATTERN-1:0] pat_all;
  logic [MAX_PATTERN-1:0] hit_vec;
  logic [7:0]             win [MAX_PATTERN];
  logic                   match;
  logic                   clear_req;
  cell_ctl_t              cell_ctl;

  // configuration port is always open; the user must write only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      pat_low_r  <= '0;
      pat_high_r <= '0;
      care_r     <= '1;
      len_r      <= LEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_ADDRESS:   base_r     <= cfg_data[ADDR_W-1:0];
        CFG_PATTERN_LOW:    pat_low_r  <= cfg_data;
        CFG_PATTERN_HIGH:   pat_high_r <= cfg_data;
        CFG_CARE_MASK:      care_r     <= cfg_data[MAX_PATTERN-1:0];
        CFG_PATTERN_LENGTH: len_r      <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_used  = used_len(len_r);
  assign pat_all = {pat_high_r, pat_low_r};

  // stall only while a result is held and the consumer is stalling
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // window bytes move only for bytes that are not after a match
  assign cell_ctl.shift_en = in_accept && !done_r;
  assign cell_ctl.clear    = clear_req;

  // cell k compares the byte received k transactions ago and lines up with
  // pattern byte n-1-k; cells at or beyond the length always hit
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [LEN_W-1:0] sel;
    logic             active;
    cell_cmp_t        cmp;
    logic [7:0]       sin;

    assign sel          = n_used - LEN_W'(k) - LEN_W'(1);
    assign active       = LEN_W'(k) < n_used;
    assign cmp.care_en  = active && care_r[sel[IDX_W-1:0]];
    assign cmp.pat_byte = pat_all[{sel[IDX_W-1:0], 3'b000} +: 8];

    if (k == 0) begin : g_head
      assign sin = in_data_byte;
    end else begin : g_body
      assign sin = win[k-1];
    end

    mbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (cell_ctl),
      .cmp       (cmp),
      .shift_in  (sin),
      .shift_out (win[k]),
      .hit       (hit_vec[k])
    );
  end

  // saturating byte count including the byte now arriving
  assign count_inc = (count_r == '1) ? count_r : count_r + ADDR_W'(1);

  // the whole window must agree and enough bytes of this region be in
  assign match = !done_r && (count_inc >= ADDR_W'(n_used)) && (&hit_vec);

  // region ends on its last byte, whatever came before
  assign clear_req = in_accept && in_last_byte;

  always_comb begin
    count_nxt     = count_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    if (in_accept) begin
      if (!done_r) begin
        count_nxt = count_inc;
        if (match) begin
          // first match: report base plus offset of the match start
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_addr_nxt  = base_r + (count_inc - ADDR_W'(n_used));
          done_nxt      = 1'b1;
        end else if (in_last_byte) begin
          // region ran out with no match
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_addr_nxt  = '0;
        end
      end
      if (in_last_byte) begin
        count_nxt = '0;
        done_nxt  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload of the result needs no reset
  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_addr_r;

`ifndef SYNTH
  // a no-match result always carries a zero address
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("no-match result with nonzero address");

  // a match inside a region blocks further results until the last byte
  a_match_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && match && !in_last_byte |=> done_r)
    else $error("match did not mark the region done");

  // the input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with no result pending");

  // ending a region empties the window
  a_window_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    clear_req |=> win[MAX_PATTERN-1] == '0 && count_r == '0)
    else $error("window or count not cleared at region end");
`endif

endmodule

### hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// one window slot: holds a byte, passes it on, compares the incoming byte
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_cmp_t  cmp,
  input  logic [7:0] shift_in,
  output logic [7:0] shift_out,
  output logic       hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.clear) begin
      byte_nxt = '0;
    end else if (ctl.shift_en) begin
      byte_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // compare against the byte that lands here this cycle
  assign hit       = !cmp.care_en || (shift_in == cmp.pat_byte);
  assign shift_out = byte_r;

endmodule
